// ===== sv/vp8frp_pkg.sv =====
// Package for the VP8 frame resolution parser.
// Holds the header constants, the parser phase type and the field widths.
// No dependencies.
`default_nettype none

package vp8frp_pkg;

    localparam int OFFSET_BITS_DEF = 24;

    localparam int BYTE_W   = 8;
    localparam int WIDTH_W  = 14;
    localparam int HEIGHT_W = 18;
    localparam int COUNT_W  = 3;
    localparam int HEAD_LEN = 14;

    localparam logic [7:0] SYNC_B0 = 8'h9d;
    localparam logic [7:0] SYNC_B1 = 8'h01;
    localparam logic [7:0] SYNC_B2 = 8'h2a;

    localparam logic [31:0] PARTS_MIN     = 32'd2;
    localparam logic [31:0] PARTS_MAX     = 32'd6;
    localparam logic [31:0] PART_SIZE_MIN = 32'd10;

    localparam int FIRST_PART     = 4;
    localparam int PLAIN_MIN_LAST = 9;   // offset of the last beat of a 10-byte buffer
    localparam int MULTI_MIN_LAST = 17;  // offset of the last beat of an 18-byte buffer
    localparam int SIZE_SLACK     = 8;
    localparam int STITCH_TRIM    = 32;

    // Offsets within one part: four size bytes, then the frame header.
    localparam int REL_SIZE_LAST = 3;
    localparam int REL_WIDTH_LO  = 10;
    localparam int REL_WIDTH_HI  = 11;
    localparam int REL_HEIGHT_LO = 12;
    localparam int REL_HEIGHT_HI = 13;

    localparam int STATUS_FOUND = 0;
    localparam int STATUS_RETRY = 1;

    typedef enum logic {
        PH_TRACK,
        PH_STOP
    } t_phase;

endpackage

`default_nettype wire

// ===== sv/vp8_frame_resolution_parser.sv =====
// VP8 frame resolution parser, top level and only module.
// Takes a frame one byte per beat and reports its resolution on the last beat.
// Depends on vp8frp_pkg.
//
// The parser takes one byte per clock and sustains one beat per cycle, unless a
// last beat waits on the result side. A beat passes one input register; the
// header tracking, the size checks and the final decision then sit in one stage
// of compares and short adds ahead of the result register, so a new beat
// follows the last beat of a frame at once. A frame's result passes the input
// register and then the result register. While a result waits, the bytes of
// the next frame keep flowing; only that frame's last beat holds in the input
// register until the waiting result is taken. Plain frames carry the start code
// 9d 01 2a at offset 3; other frames are read as a part count followed by
// size-prefixed parts. Buffers longer than 2^OFFSET_BITS bytes report status 1.
`default_nettype none

module vp8_frame_resolution_parser #(
    parameter int OFFSET_BITS = vp8frp_pkg::OFFSET_BITS_DEF
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    // tdata: data_byte[7:0]
    input  wire logic [vp8frp_pkg::BYTE_W-1:0] i_s_axis_tdata,
    input  wire logic                        i_s_axis_tlast,   // last_byte
    input  wire logic                        i_s_axis_tvalid,
    output logic                             o_s_axis_tready,
    // tdata: frame_width[13:0], frame_height[31:14], part_count[34:32], zeros
    output logic [39:0]                      o_m_axis_tdata,
    // tuser: status[0]
    output logic [0:0]                       o_m_axis_tuser,
    output logic                             o_m_axis_tvalid,
    input  wire logic                        i_m_axis_tready
);

    import vp8frp_pkg::*;

    localparam int OB = OFFSET_BITS;
    localparam int PW = OB + 1;
    localparam int SW = ((OB > 31) ? OB : 31) + 1;
    localparam logic [OB-1:0] OFS_MAX   = {OB{1'b1}};
    localparam logic [SW-1:0] SUM_LIMIT = SW'(OFS_MAX);

    // Input register.
    logic              r_in_valid;
    logic [BYTE_W-1:0] r_in_byte;
    logic              r_in_last;

    // Parser state.
    logic [OB-1:0]     r_ofs;
    logic              r_ovf;
    t_phase            r_phase, n_phase;
    logic [7:0]        r_head [HEAD_LEN];
    logic [2:0]        r_parts_seen, n_parts_seen;
    logic [PW-1:0]     r_part_start, n_part_start;
    logic [31:0]       r_part_size, n_part_size;
    logic [OB-1:0]     r_size_sum, n_size_sum;
    logic [WIDTH_W-1:0]        r_width, n_width;
    logic signed [HEIGHT_W-1:0] r_height, n_height;
    logic              r_fail, n_fail;

    // Result register.
    logic              r_out_valid;
    logic              r_status, n_status;
    logic [WIDTH_W-1:0]         r_out_w, n_out_w;
    logic signed [HEIGHT_W-1:0] r_out_h, n_out_h;
    logic [COUNT_W-1:0]         r_out_c, n_out_c;

    logic advance;
    logic s_accept;
    logic stop_req;

    logic [7:0]    hv [HEAD_LEN];
    logic [31:0]   count_word;
    logic          count_ok;
    logic [2:0]    count3;
    logic [2:0]    examined;
    logic          at_part;
    logic [PW-1:0] rel;
    logic [31:0]   size_full;
    logic [SW-1:0] sum_full;
    logic          sync3, sync11;

    assign advance  = r_in_valid && (!r_in_last || !r_out_valid || i_m_axis_tready);
    assign s_accept = i_s_axis_tvalid && o_s_axis_tready;
    assign o_s_axis_tready = !r_in_valid || advance;

    // The header bytes as they stand once the current beat is written.
    always_comb begin
        for (int i = 0; i < HEAD_LEN; i++) begin
            hv[i] = (r_ofs == OB'(i)) ? r_in_byte : r_head[i];
        end
    end

    assign count_word = {hv[3], hv[2], hv[1], hv[0]};
    assign count_ok   = (count_word >= PARTS_MIN) && (count_word <= PARTS_MAX);
    assign count3     = count_word[2:0];
    assign examined   = (count3 == 3'd2) ? 3'd1 : count3;
    assign at_part    = ({1'b0, r_ofs} >= r_part_start);
    assign rel        = {1'b0, r_ofs} - r_part_start;

    // Part tracking: size bytes, checks and the per-part header fields.
    always_comb begin
        n_parts_seen = r_parts_seen;
        n_part_start = r_part_start;
        n_part_size  = r_part_size;
        n_size_sum   = r_size_sum;
        n_width      = r_width;
        n_height     = r_height;
        n_fail       = r_fail;
        stop_req     = 1'b0;
        size_full    = r_part_size;
        sum_full     = SW'(r_size_sum);

        if (r_phase == PH_TRACK && r_ofs >= OB'(FIRST_PART)) begin
            if (!count_ok) begin
                stop_req = 1'b1;
            end else if (at_part) begin
                if (rel < PW'(4)) begin
                    unique case (rel[1:0])
                        2'd0: size_full = r_part_size | {24'd0, r_in_byte};
                        2'd1: size_full = r_part_size | {16'd0, r_in_byte, 8'd0};
                        2'd2: size_full = r_part_size | {8'd0, r_in_byte, 16'd0};
                        default: size_full = r_part_size | {r_in_byte, 24'd0};
                    endcase
                    n_part_size = size_full;
                    sum_full    = SW'(r_size_sum) + SW'(size_full[30:0]);
                    if (rel == PW'(REL_SIZE_LAST)) begin
                        if (size_full[31] || size_full < PART_SIZE_MIN) begin
                            n_fail   = 1'b1;
                            stop_req = 1'b1;
                        end else begin
                            n_size_sum = sum_full[OB-1:0];
                            if (sum_full > SUM_LIMIT) begin
                                n_fail   = 1'b1;
                                stop_req = 1'b1;
                            end
                        end
                    end
                end else if (rel == PW'(REL_WIDTH_LO)) begin
                    n_width = {6'd0, r_in_byte};
                end else if (rel == PW'(REL_WIDTH_HI)) begin
                    n_width = r_width | {r_in_byte[5:0], 8'd0};
                end else if (rel == PW'(REL_HEIGHT_LO)) begin
                    n_height = r_height + HEIGHT_W'(r_in_byte);
                end else if (rel == PW'(REL_HEIGHT_HI)) begin
                    n_height = r_height + HEIGHT_W'({r_in_byte[5:0], 8'd0});
                    // Stitched frames overlap: trim each part, inner parts twice.
                    if (examined > 3'd1) begin
                        n_height = n_height - HEIGHT_W'(STITCH_TRIM);
                        if (r_parts_seen > 3'd0 && r_parts_seen < count3 - 3'd1) begin
                            n_height = n_height - HEIGHT_W'(STITCH_TRIM);
                        end
                    end
                    n_parts_seen = r_parts_seen + 3'd1;
                    if (n_parts_seen < examined) begin
                        n_part_start = r_part_start + PW'(4) + PW'(r_part_size);
                        n_part_size  = '0;
                    end else begin
                        stop_req = 1'b1;
                    end
                end
            end
        end
    end

    always_comb begin
        n_phase = r_phase;
        if (stop_req) begin
            n_phase = PH_STOP;
        end
    end

    // Final decision on the last beat, using the state after this beat.
    assign sync3  = (hv[3] == SYNC_B0) && (hv[4] == SYNC_B1) && (hv[5] == SYNC_B2);
    assign sync11 = (hv[11] == SYNC_B0) && (hv[12] == SYNC_B1) && (hv[13] == SYNC_B2);

    always_comb begin
        n_status = 1'(STATUS_RETRY);
        n_out_w  = '0;
        n_out_h  = '0;
        n_out_c  = '0;
        if (!r_ovf && r_ofs >= OB'(PLAIN_MIN_LAST)) begin
            if (sync3) begin
                n_status = 1'(STATUS_FOUND);
                n_out_w  = {hv[7][5:0], hv[6]};
                n_out_h  = HEIGHT_W'({hv[9][5:0], hv[8]});
                n_out_c  = 3'd1;
            end else if (r_ofs >= OB'(MULTI_MIN_LAST) && sync11 && count_ok && !n_fail
                         && n_parts_seen >= examined
                         && ({1'b0, r_ofs} + PW'(1)) >= ({1'b0, n_size_sum} + PW'(SIZE_SLACK)))
            begin
                n_status = 1'(STATUS_FOUND);
                n_out_w  = n_width;
                n_out_h  = n_height;
                n_out_c  = count3;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_accept) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
        if (s_accept) begin
            r_in_byte <= i_s_axis_tdata;
            r_in_last <= i_s_axis_tlast;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && r_ofs < OB'(HEAD_LEN)) begin
            r_head[r_ofs[3:0]] <= r_in_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (advance && r_in_last)) begin
            r_ofs        <= '0;
            r_ovf        <= 1'b0;
            r_phase      <= PH_TRACK;
            r_parts_seen <= '0;
            r_part_start <= PW'(FIRST_PART);
            r_part_size  <= '0;
            r_size_sum   <= '0;
            r_width      <= '0;
            r_height     <= '0;
            r_fail       <= 1'b0;
        end else if (advance) begin
            if (r_ofs != OFS_MAX) begin
                r_ofs <= r_ofs + OB'(1);
            end else begin
                r_ovf <= 1'b1;
            end
            r_phase      <= n_phase;
            r_parts_seen <= n_parts_seen;
            r_part_start <= n_part_start;
            r_part_size  <= n_part_size;
            r_size_sum   <= n_size_sum;
            r_width      <= n_width;
            r_height     <= n_height;
            r_fail       <= n_fail;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && r_in_last) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
        if (advance && r_in_last) begin
            r_status <= n_status;
            r_out_w  <= n_out_w;
            r_out_h  <= n_out_h;
            r_out_c  <= n_out_c;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tuser  = r_status;
    assign o_m_axis_tdata  = {5'd0, r_out_c, r_out_h, r_out_w};

    // A processed last beat leaves the parser back at the start of a frame.
    a_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && r_in_last |=> r_ofs == '0 && r_phase == PH_TRACK && !r_fail)
        else $error("parser state not cleared after the last beat");

    // A found resolution always names a part count.
    a_found_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_status == 1'(STATUS_FOUND) |-> r_out_c != '0)
        else $error("found resolution without a part count");

    // A failed frame carries zero fields.
    a_retry_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_status == 1'(STATUS_RETRY)
        |-> r_out_w == '0 && r_out_h == '0 && r_out_c == '0)
        else $error("retry result carries nonzero fields");

    // No more parts are counted than a frame may hold.
    a_parts_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_parts_seen <= 3'd6)
        else $error("part counter beyond six");

    // A result still waiting blocks only a second last beat.
    a_hold_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !i_m_axis_tready && r_in_valid && r_in_last |-> !advance)
        else $error("last beat processed over a pending result");

endmodule

`default_nettype wire

// ===== tb/vp8_resolution_checker.sv =====
// Result checker for the VP8 frame resolution parser.
// Watches both stream channels, predicts each frame's resolution from the accepted bytes
// and compares it with the beats that leave the block. Depends on vp8frp_pkg.

module vp8_resolution_checker #(
    parameter int OFFSET_BITS = vp8frp_pkg::OFFSET_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic [7:0]  i_in_tdata,
    input  logic        i_in_tlast,
    input  logic        i_in_tvalid,
    input  logic        i_in_tready,
    input  logic [39:0] i_out_tdata,
    input  logic [0:0]  i_out_tuser,
    input  logic        i_out_tvalid,
    input  logic        i_out_tready,
    output int          o_mismatches,
    output int          o_waiting,
    output int          o_compared,
    output int          o_found
);

    import vp8frp_pkg::*;

    localparam longint unsigned POS_LIMIT = (64'd1 << OFFSET_BITS) - 64'd1;
    localparam int PLAIN_SYNC_AT   = 3;
    localparam int PLAIN_WIDTH_AT  = 6;
    localparam int PLAIN_HEIGHT_AT = 8;
    localparam int MULTI_SYNC_AT   = 11;

    typedef struct packed {
        logic                status;
        logic [WIDTH_W-1:0]  width;
        logic [HEIGHT_W-1:0] height;
        logic [COUNT_W-1:0]  count;
    } t_frame_res;

    // Parser state as seen from the byte stream.
    longint unsigned    pos;
    t_phase             phase;
    logic [7:0]         head [HEAD_LEN];
    int unsigned        parts_seen;
    longint unsigned    part_start;
    logic [31:0]        part_size;
    longint unsigned    size_sum;
    logic [WIDTH_W-1:0] width_acc;
    int                 height_acc;
    logic               part_failed;
    logic               pos_overflow;

    t_frame_res res_q[$];
    int mismatches = 0;
    int compared   = 0;
    int found      = 0;

    function automatic logic [31:0] head_count();
        return {head[3], head[2], head[1], head[0]};
    endfunction

    function automatic logic sync_at(input int p);
        return head[p] == SYNC_B0 && head[p+1] == SYNC_B1 && head[p+2] == SYNC_B2;
    endfunction

    function automatic logic [WIDTH_W-1:0] head_dim(input int p);
        return {head[p+1][5:0], head[p]};
    endfunction

    task automatic clear_frame();
        pos = 0;
        phase = PH_TRACK;
        foreach (head[i]) head[i] = 8'h00;
        parts_seen = 0;
        part_start = FIRST_PART;
        part_size = 0;
        size_sum = 0;
        width_acc = 0;
        height_acc = 0;
        part_failed = 1'b0;
        pos_overflow = 1'b0;
    endtask

    task automatic track_part(input longint unsigned o, input logic [7:0] b);
        logic [31:0]     n;
        int unsigned     examined;
        longint unsigned rel;
        n = head_count();
        if (n < PARTS_MIN || n > PARTS_MAX) begin
            phase = PH_STOP;
            return;
        end
        if (o < part_start) return;
        // Two-part frames only look at the first part.
        examined = (n == PARTS_MIN) ? 1 : n;
        rel = o - part_start;
        if (rel <= REL_SIZE_LAST) begin
            part_size |= 32'(b) << (8 * rel);
            if (rel == REL_SIZE_LAST) begin
                if (part_size[31] || part_size < PART_SIZE_MIN) begin
                    part_failed = 1'b1;
                    phase = PH_STOP;
                end else begin
                    size_sum += part_size;
                    if (size_sum > POS_LIMIT) begin
                        part_failed = 1'b1;
                        phase = PH_STOP;
                    end
                end
            end
        end else if (rel == REL_WIDTH_LO) begin
            width_acc = {6'b0, b};
        end else if (rel == REL_WIDTH_HI) begin
            width_acc[13:8] = b[5:0];
        end else if (rel == REL_HEIGHT_LO) begin
            height_acc += int'(b);
        end else if (rel == REL_HEIGHT_HI) begin
            height_acc += int'({b[5:0], 8'h00});
            // Stitched height: trim each part, and inner parts once more.
            if (examined > 1) begin
                height_acc -= STITCH_TRIM;
                if (parts_seen > 0 && parts_seen < n - 1) height_acc -= STITCH_TRIM;
            end
            parts_seen++;
            if (parts_seen < examined) begin
                part_start += 4 + part_size;
                part_size = 0;
            end else begin
                phase = PH_STOP;
            end
        end
    endtask

    task automatic take_byte(input logic [7:0] b, input logic is_last);
        longint unsigned o;
        longint unsigned len;
        logic [31:0]     n;
        int unsigned     examined;
        t_frame_res      r;
        o = pos;
        if (o < HEAD_LEN) head[o] = b;
        if (phase == PH_TRACK && o >= FIRST_PART) track_part(o, b);
        if (!is_last) begin
            if (o < POS_LIMIT) pos = o + 1;
            else pos_overflow = 1'b1;
            return;
        end
        len = o + 1;
        r = '0;
        r.status = 1'(STATUS_RETRY);
        if (!pos_overflow && o >= PLAIN_MIN_LAST) begin
            if (sync_at(PLAIN_SYNC_AT)) begin
                r.status = 1'(STATUS_FOUND);
                r.width  = head_dim(PLAIN_WIDTH_AT);
                r.height = HEIGHT_W'(head_dim(PLAIN_HEIGHT_AT));
                r.count  = 3'd1;
            end else if (o >= MULTI_MIN_LAST && sync_at(MULTI_SYNC_AT)) begin
                n = head_count();
                if (n >= PARTS_MIN && n <= PARTS_MAX && !part_failed) begin
                    examined = (n == PARTS_MIN) ? 1 : n;
                    if (parts_seen >= examined && len >= SIZE_SLACK + size_sum) begin
                        r.status = 1'(STATUS_FOUND);
                        r.width  = width_acc;
                        r.height = HEIGHT_W'(height_acc);
                        r.count  = n[COUNT_W-1:0];
                    end
                end
            end
        end
        res_q.push_back(r);
        clear_frame();
    endtask

    task automatic note_field(input string what, input logic [31:0] want_v,
                              input logic [31:0] got_v);
        if (want_v !== got_v) begin
            mismatches++;
            $display("%0t: %s expected 0x%0h, got 0x%0h", $time, what, want_v, got_v);
        end
    endtask

    always @(posedge i_clk) begin
        t_frame_res got;
        t_frame_res want;
        if (!i_rst_n) begin
            clear_frame();
        end else begin
            // A result passes the input and result registers after its last byte, so the
            // output beat is always older than a byte taken at the same edge.
            if (i_out_tvalid && i_out_tready) begin
                got.status = i_out_tuser[0];
                got.width  = i_out_tdata[13:0];
                got.height = i_out_tdata[31:14];
                got.count  = i_out_tdata[34:32];
                if (res_q.size() == 0) begin
                    mismatches++;
                    $display("%0t: result beat with no frame pending, expected none, got 0x%0h",
                             $time, got);
                end else begin
                    want = res_q.pop_front();
                    compared++;
                    if (want.status == 1'(STATUS_FOUND)) found++;
                    note_field("status", 32'(want.status), 32'(got.status));
                    note_field("frame_width", 32'(want.width), 32'(got.width));
                    note_field("frame_height", 32'(want.height), 32'(got.height));
                    note_field("part_count", 32'(want.count), 32'(got.count));
                end
            end
            if (i_in_tvalid && i_in_tready) take_byte(i_in_tdata, i_in_tlast);
        end
        o_mismatches <= mismatches;
        o_waiting    <= res_q.size();
        o_compared   <= compared;
        o_found      <= found;
    end

endmodule

// ===== tb/tb_vp8_frame_resolution_parser.sv =====
// Testbench top for the VP8 frame resolution parser.
// Builds plain, multi-part, flawed and noise frames, drives them with random gaps and
// output stalls, and takes the verdict from vp8_resolution_checker. Depends on vp8frp_pkg.

module tb_vp8_frame_resolution_parser;
    import vp8frp_pkg::*;

    typedef enum int {
        FLAW_NONE,
        FLAW_NEG_SIZE,
        FLAW_TINY_SIZE,
        FLAW_HUGE_SIZE,
        FLAW_OVERSTATED,
        FLAW_TRUNCATED,
        FLAW_NO_SYNC,
        FLAW_BAD_COUNT
    } t_flaw;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic [7:0]  in_tdata = 8'h00;
    logic        in_tlast = 1'b0;
    logic        in_tvalid = 1'b0;
    logic        out_tready = 1'b0;
    wire         in_tready;
    wire  [39:0] out_tdata;
    wire  [0:0]  out_tuser;
    wire         out_tvalid;

    int mismatches;
    int waiting;
    int compared;
    int found;

    logic [7:0] frame_q[$];
    bit         steady = 1'b0;
    int         beats = 0;
    int         frames = 0;

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    vp8_frame_resolution_parser DUT (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tdata  (in_tdata),
        .i_s_axis_tlast  (in_tlast),
        .i_s_axis_tvalid (in_tvalid),
        .o_s_axis_tready (in_tready),
        .o_m_axis_tdata  (out_tdata),
        .o_m_axis_tuser  (out_tuser),
        .o_m_axis_tvalid (out_tvalid),
        .i_m_axis_tready (out_tready)
    );

    vp8_resolution_checker u_res_check (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_tdata   (in_tdata),
        .i_in_tlast   (in_tlast),
        .i_in_tvalid  (in_tvalid),
        .i_in_tready  (in_tready),
        .i_out_tdata  (out_tdata),
        .i_out_tuser  (out_tuser),
        .i_out_tvalid (out_tvalid),
        .i_out_tready (out_tready),
        .o_mismatches (mismatches),
        .o_waiting    (waiting),
        .o_compared   (compared),
        .o_found      (found)
    );

    // The result side stalls with a probability of 21 percent, except in the steady stretch.
    always @(posedge clk) begin
        out_tready <= steady || ($urandom_range(0, 99) >= 21);
    end

    task automatic put_le(input logic [31:0] v, input int nbytes);
        for (int i = 0; i < nbytes; i++) frame_q.push_back(v[8*i +: 8]);
    endtask

    task automatic put_random(input int nbytes);
        for (int i = 0; i < nbytes; i++) frame_q.push_back(8'($urandom));
    endtask

    task automatic set_count(input logic [31:0] v);
        for (int i = 0; i < 4; i++) frame_q[i] = v[8*i +: 8];
    endtask

    task automatic cut_to(input int len);
        while (frame_q.size() > len) void'(frame_q.pop_back());
    endtask

    task automatic build_plain(input logic [15:0] w, input logic [15:0] h, input int tail);
        frame_q.delete();
        put_random(3);
        frame_q.push_back(SYNC_B0);
        frame_q.push_back(SYNC_B1);
        frame_q.push_back(SYNC_B2);
        put_le(w, 2);
        put_le(h, 2);
        put_random(tail);
    endtask

    task automatic build_parts(input int n, input t_flaw flaw, input int body_max,
                               input bit fixed_dims, input logic [15:0] dim_val);
        int          bad_part;
        int          body;
        int          which;
        logic [31:0] size;
        logic [7:0]  sync [3];
        frame_q.delete();
        put_le(n, 4);
        bad_part = $urandom_range(0, n - 1);
        for (int p = 0; p < n; p++) begin
            body = $urandom_range(10, body_max);
            size = body;
            if (p == bad_part) begin
                case (flaw)
                    FLAW_NEG_SIZE:   size = $urandom | 32'h8000_0000;
                    FLAW_TINY_SIZE:  size = $urandom_range(0, 9);
                    FLAW_HUGE_SIZE: begin
                        // Either past the offset range or just large enough to run away.
                        if ($urandom_range(0, 1) == 0) begin
                            size = ($urandom & 32'h7fff_ffff) | 32'h0100_0000;
                        end else begin
                            size = $urandom_range(32'h0000_1000, 32'h00ff_ffff);
                        end
                    end
                    FLAW_OVERSTATED: size = body + $urandom_range(1, 40);
                    default:         size = body;
                endcase
            end
            put_le(size, 4);
            put_random(3);
            sync = '{SYNC_B0, SYNC_B1, SYNC_B2};
            if (flaw == FLAW_NO_SYNC && p == 0) begin
                which = $urandom_range(0, 2);
                sync[which] = sync[which] ^ 8'($urandom_range(1, 255));
            end
            foreach (sync[i]) frame_q.push_back(sync[i]);
            put_le(fixed_dims ? dim_val : 16'($urandom), 2);
            put_le(fixed_dims ? dim_val : 16'($urandom), 2);
            put_random(body - 10);
        end
        if (flaw == FLAW_TRUNCATED) cut_to($urandom_range(1, frame_q.size() - 1));
        if (flaw == FLAW_BAD_COUNT) begin
            case ($urandom_range(0, 3))
                0:       set_count(32'd0);
                1:       set_count(32'd1);
                2:       set_count($urandom_range(7, 255));
                default: set_count($urandom | 32'h0100_0000);
            endcase
        end
    endtask

    task automatic send_beat(input logic [7:0] b, input logic is_last);
        while (!steady && $urandom_range(0, 99) < 21) begin
            in_tvalid <= 1'b0;
            @(posedge clk);
        end
        in_tvalid <= 1'b1;
        in_tdata  <= b;
        in_tlast  <= is_last;
        @(posedge clk);
        while (!in_tready) @(posedge clk);
        beats++;
    endtask

    task automatic send_frame();
        foreach (frame_q[i]) send_beat(frame_q[i], i == frame_q.size() - 1);
        frames++;
    endtask

    initial begin
        int pick;
        int k;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed frames: plain extremes and short buffers.
        build_plain(16'h0000, 16'h0000, 0);
        send_frame();
        build_plain(16'hffff, 16'hffff, 5);
        send_frame();
        build_plain(16'($urandom), 16'($urandom), 4);
        cut_to(9);
        send_frame();
        frame_q.delete();
        put_random(1);
        send_frame();

        // Well-formed multi-part frames, with the largest and smallest stitched heights.
        build_parts(2, FLAW_NONE, 16, 0, 16'h0);
        send_frame();
        build_parts(3, FLAW_NONE, 16, 0, 16'h0);
        send_frame();
        build_parts(6, FLAW_NONE, 16, 1, 16'hffff);
        send_frame();
        build_parts(6, FLAW_NONE, 16, 1, 16'h0000);
        send_frame();
        build_parts(4, FLAW_NONE, 10, 0, 16'h0);
        send_frame();

        // Part counts out of range.
        build_parts(3, FLAW_NONE, 16, 0, 16'h0);
        set_count(32'd0);
        send_frame();
        build_parts(3, FLAW_NONE, 16, 0, 16'h0);
        set_count(32'd1);
        send_frame();
        build_parts(3, FLAW_NONE, 16, 0, 16'h0);
        set_count(32'd7);
        send_frame();
        build_parts(3, FLAW_NONE, 16, 0, 16'h0);
        set_count(32'hffff_ffff);
        send_frame();

        // Bad part sizes, truncation, missing start code and a short multi-part buffer.
        build_parts(3, FLAW_NEG_SIZE, 16, 0, 16'h0);
        send_frame();
        build_parts(3, FLAW_TINY_SIZE, 16, 0, 16'h0);
        send_frame();
        build_parts(3, FLAW_HUGE_SIZE, 16, 0, 16'h0);
        send_frame();
        build_parts(2, FLAW_OVERSTATED, 16, 0, 16'h0);
        send_frame();
        build_parts(5, FLAW_TRUNCATED, 16, 0, 16'h0);
        send_frame();
        build_parts(3, FLAW_NO_SYNC, 16, 0, 16'h0);
        send_frame();
        build_parts(3, FLAW_NONE, 16, 0, 16'h0);
        cut_to(17);
        send_frame();

        // Random frames, mostly well formed so the part walk gets exercised.
        k = 0;
        while (beats < 1400 || k < 8) begin
            steady = (k >= 2 && k < 6);
            pick = $urandom_range(0, 99);
            if (pick < 25) begin
                build_plain(16'($urandom), 16'($urandom), $urandom_range(0, 12));
                if ($urandom_range(0, 9) == 0) cut_to($urandom_range(1, 9));
            end else if (pick < 70) begin
                build_parts($urandom_range(2, 6), FLAW_NONE,
                            ($urandom_range(0, 9) == 0) ? 60 : 16, 0, 16'h0);
            end else if (pick < 90) begin
                build_parts($urandom_range(2, 6),
                            t_flaw'($urandom_range(FLAW_NEG_SIZE, FLAW_BAD_COUNT)),
                            16, 0, 16'h0);
            end else begin
                frame_q.delete();
                put_random($urandom_range(1, 40));
            end
            send_frame();
            k++;
        end
        steady = 1'b0;
        in_tvalid <= 1'b0;

        @(posedge clk);
        while (waiting != 0) @(posedge clk);
        repeat (8) @(posedge clk);

        $display("Drove %0d bytes in %0d frames (plain, multi-part, flawed and noise).",
                 beats, frames);
        $display("Checked %0d results, %0d of them with a resolution found.", compared, found);
        if (mismatches == 0 && waiting == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("Timeout with %0d results still pending.", waiting);
        $display("Test completed with failures");
        $finish;
    end

endmodule

// ===== files.f =====
sv/vp8frp_pkg.sv
sv/vp8_frame_resolution_parser.sv
tb/vp8_resolution_checker.sv
tb/tb_vp8_frame_resolution_parser.sv
